// ===== rtl/cbpg_pkg.sv =====
// Shared types, widths and arithmetic helpers for the cubic Bezier point generator.
package cbpg_pkg;

    // Coordinate and fixed-point widths.
    localparam int COORD_BITS = 16;
    localparam int T_W        = 16;
    localparam int Q_W        = T_W + 1;
    localparam int COEF_W     = COORD_BITS + 4;
    localparam int H1_W       = COEF_W + T_W + 1;
    localparam int H2_W       = H1_W + 1;
    localparam int H3_W       = H2_W + 1;
    localparam int AXES       = 3;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int PC_W       = 7;
    localparam logic [0:0]      REG_POINT_COUNT = 1'b0;
    localparam logic [PC_W-1:0] PC_RESET        = 7'd10;

    // Rounding and saturation limits on the final Horner sum.
    localparam logic signed [H3_W-1:0] ROUND_HALF = H3_W'(1) <<< (T_W - 1);
    localparam logic signed [H3_W-1:0] SAT_HI     = H3_W'((2 ** (COORD_BITS - 1)) - 1);
    localparam logic signed [H3_W-1:0] SAT_LO     = H3_W'(-(2 ** (COORD_BITS - 1)));

    // One request: four control points in three axes.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] p0_x;
        logic signed [COORD_BITS-1:0] p0_y;
        logic signed [COORD_BITS-1:0] p0_z;
        logic signed [COORD_BITS-1:0] p1_x;
        logic signed [COORD_BITS-1:0] p1_y;
        logic signed [COORD_BITS-1:0] p1_z;
        logic signed [COORD_BITS-1:0] p2_x;
        logic signed [COORD_BITS-1:0] p2_y;
        logic signed [COORD_BITS-1:0] p2_z;
        logic signed [COORD_BITS-1:0] p3_x;
        logic signed [COORD_BITS-1:0] p3_y;
        logic signed [COORD_BITS-1:0] p3_z;
    } pts_item_t;

    // One result: a curve point.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] curve_x;
        logic signed [COORD_BITS-1:0] curve_y;
        logic signed [COORD_BITS-1:0] curve_z;
        logic                         last_point;
    } crv_item_t;

    // Power-basis coefficients of one axis.
    typedef struct packed {
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
        logic signed [COEF_W-1:0] d;
    } coef_t;

    typedef coef_t [AXES-1:0] coef_set_t;

    // Status of the point generator towards the lanes.
    typedef struct packed {
        logic valid;
        logic last;
    } gen_ctl_t;

    // Coefficients from the four control points of one axis.
    function automatic coef_t calc_coef(input logic signed [COORD_BITS-1:0] p0,
                                        input logic signed [COORD_BITS-1:0] p1,
                                        input logic signed [COORD_BITS-1:0] p2,
                                        input logic signed [COORD_BITS-1:0] p3);
        logic signed [COEF_W-1:0] e0;
        logic signed [COEF_W-1:0] e1;
        logic signed [COEF_W-1:0] e2;
        logic signed [COEF_W-1:0] e3;
        logic signed [COEF_W-1:0] d12;
        logic signed [COEF_W-1:0] s;
        logic signed [COEF_W-1:0] d10;
        coef_t                    k;
        e0  = COEF_W'(p0);
        e1  = COEF_W'(p1);
        e2  = COEF_W'(p2);
        e3  = COEF_W'(p3);
        d12 = e1 - e2;
        s   = e0 - (e1 <<< 1) + e2;
        d10 = e1 - e0;
        k.a = e3 - e0 + (d12 <<< 1) + d12;
        k.b = (s <<< 1) + s;
        k.c = (d10 <<< 1) + d10;
        k.d = e0;
        return k;
    endfunction

    // Round half up from Q.16 and clamp to the coordinate range.
    function automatic logic signed [COORD_BITS-1:0] round_sat(
        input logic signed [H3_W-1:0] h);
        logic signed [H3_W-1:0] rs;
        rs = (h + ROUND_HALF) >>> T_W;
        if (rs > SAT_HI)
        begin
            return COORD_BITS'(SAT_HI);
        end
        else if (rs < SAT_LO)
        begin
            return COORD_BITS'(SAT_LO);
        end
        return COORD_BITS'(rs);
    endfunction

endpackage

// ===== rtl/cbpg_step_div.sv =====
// Bit-serial divider that turns the point count into the parameter step 65536/n.
module cbpg_step_div #(
    parameter int MAX_POINTS = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [$clog2(MAX_POINTS + 1)-1:0]    n_eff,
    output logic                                 busy,
    output logic [cbpg_pkg::Q_W-1:0]             step_q,
    output logic [$clog2(MAX_POINTS + 1)-1:0]    step_r
);

    localparam int NW    = $clog2(MAX_POINTS + 1);
    localparam int CNT_W = $clog2(cbpg_pkg::Q_W);
    localparam logic [cbpg_pkg::Q_W-1:0] DIVIDEND = cbpg_pkg::Q_W'(1) << cbpg_pkg::T_W;

    logic                    busy_reg;
    logic                    busy_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    logic [NW-1:0]           rem_reg;
    logic [NW-1:0]           rem_next;
    logic [cbpg_pkg::Q_W-1:0] quo_reg;
    logic [cbpg_pkg::Q_W-1:0] quo_next;
    logic [NW:0]             trial;
    logic                    fits;

    // One restoring step per cycle, most significant dividend bit first.
    always_comb
    begin
        trial     = {rem_reg, DIVIDEND[cnt_reg]};
        fits      = (trial >= {1'b0, n_eff});
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(cbpg_pkg::Q_W - 1);
            rem_next  = '0;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? NW'(trial - {1'b0, n_eff}) : NW'(trial);
            quo_next = {quo_reg[cbpg_pkg::Q_W-2:0], fits};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    // The reset value of the point count is divided straight after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(cbpg_pkg::Q_W - 1);
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
        end
    end

    assign busy   = busy_reg;
    assign step_q = quo_reg;
    assign step_r = rem_reg;

    // A finished step must reproduce the dividend exactly.
    a_step_exact: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (32'(quo_reg) * 32'(n_eff) + 32'(rem_reg) == 32'(DIVIDEND)))
        else $error("step quotient and remainder do not rebuild 65536");

endmodule

// ===== rtl/cbpg_point_gen.sv =====
// Per-request coefficients and parameter sequencer; one point a cycle on advance.
module cbpg_point_gen #(
    parameter int MAX_POINTS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic                              advance,
    input  cbpg_pkg::pts_item_t               pts,
    input  logic [$clog2(MAX_POINTS + 1)-1:0] n_eff,
    input  logic [cbpg_pkg::Q_W-1:0]          step_q,
    input  logic [$clog2(MAX_POINTS + 1)-1:0] step_r,
    output cbpg_pkg::gen_ctl_t                ctl,
    output logic [cbpg_pkg::T_W-1:0]          t,
    output cbpg_pkg::coef_set_t               coef
);

    localparam int NW = $clog2(MAX_POINTS + 1);

    logic                     active_reg;
    logic                     active_next;
    logic [NW-1:0]            idx_reg;
    logic [NW-1:0]            idx_next;
    logic [cbpg_pkg::Q_W-1:0] q_reg;
    logic [cbpg_pkg::Q_W-1:0] q_next;
    logic [NW-1:0]            r_reg;
    logic [NW-1:0]            r_next;
    cbpg_pkg::coef_set_t      coef_reg;
    cbpg_pkg::coef_set_t      coef_next;
    logic                     last;
    logic [NW:0]              r_sum;
    logic                     carry;

    assign last  = (idx_reg == n_eff - NW'(1));
    assign r_sum = {1'b0, r_reg} + {1'b0, step_r};
    assign carry = (r_sum >= {1'b0, n_eff});

    // Next parameter: add the step and carry the remainder, or load a new request.
    always_comb
    begin
        active_next = active_reg;
        idx_next    = idx_reg;
        q_next      = q_reg;
        r_next      = r_reg;
        coef_next   = coef_reg;
        if (accept)
        begin
            active_next = 1'b1;
            idx_next    = '0;
            q_next      = '0;
            r_next      = '0;
            coef_next[0] = cbpg_pkg::calc_coef(pts.p0_x, pts.p1_x, pts.p2_x, pts.p3_x);
            coef_next[1] = cbpg_pkg::calc_coef(pts.p0_y, pts.p1_y, pts.p2_y, pts.p3_y);
            coef_next[2] = cbpg_pkg::calc_coef(pts.p0_z, pts.p1_z, pts.p2_z, pts.p3_z);
        end
        else if (advance && active_reg)
        begin
            if (last)
            begin
                active_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + NW'(1);
                q_next   = q_reg + step_q + cbpg_pkg::Q_W'(carry);
                r_next   = carry ? NW'(r_sum - {1'b0, n_eff}) : NW'(r_sum);
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
            q_reg      <= '0;
            r_reg      <= '0;
        end
        else
        begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
            q_reg      <= q_next;
            r_reg      <= r_next;
        end
    end

    // Coefficients of the request being expanded.
    always_ff @(posedge clk)
    begin
        coef_reg <= coef_next;
    end

    assign ctl.valid = active_reg;
    assign ctl.last  = last;
    assign t         = q_reg[cbpg_pkg::T_W-1:0];
    assign coef      = coef_reg;

    // The parameter strictly grows from one point of a curve to the next.
    a_t_rises: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && advance && !last) |=> (q_reg > $past(q_reg)))
        else $error("curve parameter failed to advance");

endmodule

// ===== rtl/cbpg_axis_lane.sv =====
// Three-stage Horner evaluator for one axis of the curve.
module cbpg_axis_lane (
    input  logic                                clk,
    input  logic                                advance,
    input  cbpg_pkg::coef_t                     coef,
    input  logic [cbpg_pkg::T_W-1:0]            t,
    output logic signed [cbpg_pkg::H3_W-1:0]    h3
);

    localparam int T_W    = cbpg_pkg::T_W;
    localparam int COEF_W = cbpg_pkg::COEF_W;
    localparam int H1_W   = cbpg_pkg::H1_W;
    localparam int H2_W   = cbpg_pkg::H2_W;
    localparam int H3_W   = cbpg_pkg::H3_W;
    localparam int P2_W   = H1_W + T_W + 1;
    localparam int P3_W   = H2_W + T_W + 1;

    logic signed [T_W:0]      ts0;
    logic signed [T_W:0]      ts1;
    logic signed [T_W:0]      ts2;
    logic signed [H1_W-1:0]   at_prod;
    logic signed [H1_W-1:0]   h1_next;
    logic signed [H1_W-1:0]   h1_reg;
    logic signed [COEF_W-1:0] c1_reg;
    logic signed [COEF_W-1:0] d1_reg;
    logic [T_W-1:0]           t1_reg;
    logic signed [P2_W-1:0]   prod2;
    logic signed [H2_W-1:0]   h2_next;
    logic signed [H2_W-1:0]   h2_reg;
    logic signed [COEF_W-1:0] d2_reg;
    logic [T_W-1:0]           t2_reg;
    logic signed [P3_W-1:0]   prod3;
    logic signed [H3_W-1:0]   h3_next;
    logic signed [H3_W-1:0]   h3_reg;

    assign ts0 = $signed({1'b0, t});
    assign ts1 = $signed({1'b0, t1_reg});
    assign ts2 = $signed({1'b0, t2_reg});

    // Stage one: a*t + b, exact in Q.16.
    assign at_prod = coef.a * ts0;
    assign h1_next = at_prod + (H1_W'(coef.b) <<< T_W);

    // Stage two: floor(h1*t) + c.
    assign prod2   = h1_reg * ts1;
    assign h2_next = H2_W'(prod2 >>> T_W) + (H2_W'(c1_reg) <<< T_W);

    // Stage three: floor(h2*t) + d.
    assign prod3   = h2_reg * ts2;
    assign h3_next = H3_W'(prod3 >>> T_W) + (H3_W'(d2_reg) <<< T_W);

    // The lane moves only when the whole pipeline moves.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            h1_reg <= h1_next;
            c1_reg <= coef.c;
            d1_reg <= coef.d;
            t1_reg <= t;
            h2_reg <= h2_next;
            d2_reg <= d1_reg;
            t2_reg <= t1_reg;
            h3_reg <= h3_next;
        end
    end

    assign h3 = h3_reg;

endmodule

// ===== rtl/cubic_bezier_point_generator_unit.sv =====
// Top level of the cubic Bezier point generator: configuration, lanes and result merge.
//
//  Channel   Handshake             Payload    Direction  Purpose
//  pts       pts_valid/pts_stall   pts_data   in         four 3-D control points
//  crv       crv_valid/crv_stall   crv_data   out        one curve point, last flag
//  apb       psel/penable/pready   pwdata     in/out     point_count register
//
// Each request yields n_eff points (point_count, zero taken as one, clipped to
// MAX_POINTS, so 1 to MAX_POINTS), one per cycle while crv does not stall.
// After a request is accepted, its first point passes the sequencer registers, the
// three Horner stages and the output register before it is offered.
// After reset and after every point_count write a bit-serial divider runs, and
// pts_stall is held high while it is busy.
// A stall on crv freezes the whole pipeline; the next request is taken while the
// last point of the current one is being issued.
module cubic_bezier_point_generator_unit #(
    parameter int MAX_POINTS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cbpg_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [cbpg_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [cbpg_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    input  logic                                pts_valid,
    output logic                                pts_stall,
    input  cbpg_pkg::pts_item_t                 pts_data,
    output logic                                crv_valid,
    input  logic                                crv_stall,
    output cbpg_pkg::crv_item_t                 crv_data
);

    localparam int NW = $clog2(MAX_POINTS + 1);

    logic [cbpg_pkg::PC_W-1:0] pc_reg;
    logic [cbpg_pkg::PC_W-1:0] pc_next;
    logic                      reg_sel;
    logic                      cfg_write;
    logic [NW-1:0]             n_eff;
    logic                      div_busy;
    logic [cbpg_pkg::Q_W-1:0]  step_q;
    logic [NW-1:0]             step_r;
    logic                      advance;
    logic                      pts_ready;
    logic                      accept;
    cbpg_pkg::gen_ctl_t        gen_ctl;
    logic [cbpg_pkg::T_W-1:0]  gen_t;
    cbpg_pkg::coef_set_t       gen_coef;
    logic signed [cbpg_pkg::H3_W-1:0] lane_h3 [cbpg_pkg::AXES];
    logic                      v1_reg;
    logic                      v2_reg;
    logic                      v3_reg;
    logic                      l1_reg;
    logic                      l2_reg;
    logic                      l3_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    cbpg_pkg::crv_item_t       out_item_reg;
    cbpg_pkg::crv_item_t       out_item_next;

    // Register file access.
    assign pready    = 1'b1;
    assign reg_sel   = (paddr[cbpg_pkg::APB_ADDR_W-1:2] == cbpg_pkg::REG_POINT_COUNT);
    assign cfg_write = psel && penable && pwrite && pready && reg_sel;
    assign pc_next   = cfg_write ? pwdata[cbpg_pkg::PC_W-1:0] : pc_reg;

    always_comb
    begin
        prdata = '0;
        if (reg_sel)
        begin
            prdata = cbpg_pkg::APB_DATA_W'(pc_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= cbpg_pkg::PC_RESET;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    // Effective point count: zero means one, large values clip to the maximum.
    always_comb
    begin
        if (pc_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (32'(pc_reg) > MAX_POINTS)
        begin
            n_eff = NW'(MAX_POINTS);
        end
        else
        begin
            n_eff = NW'(pc_reg);
        end
    end

    // Parameter step from the point count.
    cbpg_step_div #(
        .MAX_POINTS (MAX_POINTS)
    ) u_step_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cfg_write),
        .n_eff  (n_eff),
        .busy   (div_busy),
        .step_q (step_q),
        .step_r (step_r)
    );

    // Flow control: the pipeline moves whenever the output register can take a point.
    assign advance   = !out_valid_reg || !crv_stall;
    assign pts_ready = !div_busy && (!gen_ctl.valid || (advance && gen_ctl.last));
    assign pts_stall = !pts_ready;
    assign accept    = pts_valid && pts_ready;

    cbpg_point_gen #(
        .MAX_POINTS (MAX_POINTS)
    ) u_point_gen (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .advance (advance),
        .pts     (pts_data),
        .n_eff   (n_eff),
        .step_q  (step_q),
        .step_r  (step_r),
        .ctl     (gen_ctl),
        .t       (gen_t),
        .coef    (gen_coef)
    );

    // One Horner lane per axis.
    for (genvar ax = 0; ax < cbpg_pkg::AXES; ax++)
    begin : g_lane
        cbpg_axis_lane u_lane (
            .clk     (clk),
            .advance (advance),
            .coef    (gen_coef[ax]),
            .t       (gen_t),
            .h3      (lane_h3[ax])
        );
    end

    // Valid and last flags travel alongside the lane stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            l1_reg <= 1'b0;
            l2_reg <= 1'b0;
            l3_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= gen_ctl.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            l1_reg <= gen_ctl.last;
            l2_reg <= l1_reg;
            l3_reg <= l2_reg;
        end
    end

    // Merge: round and clamp each lane and join them with the last flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (advance)
        begin
            out_valid_next           = v3_reg;
            out_item_next.curve_x    = cbpg_pkg::round_sat(lane_h3[0]);
            out_item_next.curve_y    = cbpg_pkg::round_sat(lane_h3[1]);
            out_item_next.curve_z    = cbpg_pkg::round_sat(lane_h3[2]);
            out_item_next.last_point = l3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign crv_valid = out_valid_reg;
    assign crv_data  = out_item_reg;

    // A point only appears at the output after passing the last lane stage.
    a_out_from_lane: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(v3_reg))
        else $error("output point appeared without a lane result");

endmodule
